// File: rtl/sgm_pkg.sv
// Shared constants for the Sobel gradient magnitude block.
// No dependencies; imported by sobel_gradient_magnitude.
`default_nettype none

package sgm_pkg;

    localparam int PIX_W       = 8;
    localparam int CFG_W       = 11;
    localparam int CFG_INDEX_W = 2;

    // register indexes on the configuration channel
    localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;

    // square root: 18-bit radicand, two bits per step
    localparam int ROOT_W     = 18;
    localparam int ROOT_STEPS = 9;
    localparam int STEP_W     = 4;

    localparam int SQ_W = 2 * PIX_W;

    typedef logic [PIX_W-1:0] pix_t;

endpackage

`default_nettype wire

// File: rtl/sobel_gradient_magnitude.sv
// Streaming 3x3 Sobel gradient magnitude with zero padding.
// Depends on sgm_pkg for widths and register indexes.
// Flow: a word that yields a result passes the CALC, MUL, SUM, ROOT and PUT states
// before it shows on m_tvalid; PUT waits while the last output is not yet taken. Words
// are taken only in IDLE, paced by the one-port line memory and the 9-step square root.
// Reset: synchronous, active low; then a clearing pass over all MAX_WIDTH addresses zeroes the
// line memory while s_tready stays low (configuration writes are still taken).
`default_nettype none

module sobel_gradient_magnitude
    import sgm_pkg::*;
#(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  wire                    aclk,
    input  wire                    aresetn,
    input  wire                    s_tvalid,
    output logic                   s_tready,
    input  wire  [7:0]             s_tdata,   // [7:0] pixel
    input  wire                    s_tuser,   // [0] flush
    output logic                   m_tvalid,
    input  wire                    m_tready,
    output logic [23:0]            m_tdata,   // [7:0] vertical_response,
                                              // [15:8] horizontal_response, [23:16] magnitude
    output logic                   m_tlast,   // frame_end
    input  wire                    cfg_valid,
    output logic                   cfg_ready,
    input  wire  [CFG_INDEX_W-1:0] cfg_index,
    input  wire  [CFG_W-1:0]       cfg_data
);

    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int COLP_W = COL_W + 1;
    localparam int ROW_W  = $clog2(MAX_HEIGHT + 2);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_CALC = 3'd1;
    localparam logic [2:0] ST_MUL  = 3'd2;
    localparam logic [2:0] ST_SUM  = 3'd3;
    localparam logic [2:0] ST_ROOT = 3'd4;
    localparam logic [2:0] ST_PUT  = 3'd5;

    // line memory: [15:8] row two above, [7:0] row one above
    logic [2*PIX_W-1:0] line_mem [0:MAX_WIDTH-1];
    logic [2*PIX_W-1:0] rd_reg;
    logic               mem_we;
    logic [COL_W-1:0]   mem_addr;
    logic [2*PIX_W-1:0] mem_wdata;

    logic [2:0]         state_reg;
    logic               clr_reg;
    logic [COL_W-1:0]   clr_addr_reg;
    logic [CFG_W-1:0]   width_reg;
    logic [CFG_W-1:0]   height_reg;
    logic [COL_W-1:0]   col_reg;
    logic [ROW_W-1:0]   row_reg;
    pix_t               pix_in_reg;
    logic               flush_reg;
    pix_t               win_reg [0:2][0:2];
    pix_t               win1 [0:2][0:2];
    pix_t               win2 [0:2][0:2];
    pix_t               ew   [0:2][0:2];

    pix_t               cv_reg;
    pix_t               ch_reg;
    logic               last_reg;
    logic [SQ_W-1:0]    sqv_reg;
    logic [SQ_W-1:0]    sqh_reg;
    logic [ROOT_W-1:0]  rem_reg;
    logic [ROOT_W-1:0]  res_reg;
    logic [STEP_W-1:0]  step_reg;

    logic               out_valid_reg;
    pix_t               out_v_reg;
    pix_t               out_h_reg;
    pix_t               out_m_reg;
    logic               out_last_reg;

    logic [COLP_W-1:0]  w_eff;
    logic [ROW_W-1:0]   h_eff;
    logic               c_zero;
    logic               row_ge1;
    logic               row_ge2;
    logic               row_in_pad;
    logic               row_last;
    logic               emit_early;
    logic               frame_done;
    logic               emit;
    logic               row_end;
    pix_t               pix_eff;
    pix_t               top;
    pix_t               mid;
    logic [9:0]         sum_lo;
    logic [9:0]         sum_hi;
    logic [9:0]         sum_rt;
    logic [9:0]         sum_lf;
    logic signed [10:0] gv;
    logic signed [10:0] gh;
    pix_t               cv_next;
    pix_t               ch_next;
    logic [COL_W-1:0]   col_next;
    logic [ROW_W-1:0]   row_next;
    logic [ROOT_W-1:0]  root_bit;
    logic [ROOT_W-1:0]  root_trial;
    logic               accept;
    logic               put_ok;

    assign s_tready  = (state_reg == ST_IDLE) && !clr_reg;
    assign accept    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = {out_m_reg, out_h_reg, out_v_reg};
    assign m_tlast   = out_last_reg;
    assign put_ok    = !out_valid_reg || m_tready;

    // effective geometry: zero counts as one, above the maximum counts as the maximum
    always_comb begin
        if (width_reg == '0) begin
            w_eff = COLP_W'(1);
        end else if ({21'b0, width_reg} > MAX_WIDTH) begin
            w_eff = COLP_W'(MAX_WIDTH);
        end else begin
            w_eff = COLP_W'(width_reg);
        end
        if (height_reg == '0) begin
            h_eff = ROW_W'(1);
        end else if ({21'b0, height_reg} > MAX_HEIGHT) begin
            h_eff = ROW_W'(MAX_HEIGHT);
        end else begin
            h_eff = ROW_W'(height_reg);
        end
    end

    assign c_zero     = (col_reg == '0);
    assign row_ge1    = (row_reg >= ROW_W'(1));
    assign row_ge2    = (row_reg >= ROW_W'(2));
    assign row_in_pad = (row_reg >= h_eff);
    assign row_last   = ({1'b0, row_reg} >= ({1'b0, h_eff} + 1'b1));
    assign emit_early = c_zero && row_ge2;
    assign frame_done = emit_early && row_last;
    assign emit       = emit_early || (!c_zero && row_ge1);
    assign row_end    = (({1'b0, col_reg} + 1'b1) >= w_eff);

    assign pix_eff = (flush_reg || row_in_pad) ? '0 : pix_in_reg;
    assign top     = row_ge2 ? rd_reg[2*PIX_W-1:PIX_W] : '0;
    assign mid     = row_ge1 ? rd_reg[PIX_W-1:0] : '0;

    // window moves: right padding column at column zero, then the new column
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            if (c_zero) begin
                win1[k][0] = win_reg[k][1];
                win1[k][1] = win_reg[k][2];
                win1[k][2] = '0;
            end else begin
                win1[k][0] = win_reg[k][0];
                win1[k][1] = win_reg[k][1];
                win1[k][2] = win_reg[k][2];
            end
            win2[k][0] = win1[k][1];
            win2[k][1] = win1[k][2];
        end
        win2[0][2] = top;
        win2[1][2] = mid;
        win2[2][2] = pix_eff;
        for (int k = 0; k < 3; k++) begin
            for (int j = 0; j < 3; j++) begin
                ew[k][j] = c_zero ? win1[k][j] : win2[k][j];
            end
        end
    end

    always_comb begin
        sum_lo = {2'b0, ew[2][0]} + {1'b0, ew[2][1], 1'b0} + {2'b0, ew[2][2]};
        sum_hi = {2'b0, ew[0][0]} + {1'b0, ew[0][1], 1'b0} + {2'b0, ew[0][2]};
        sum_rt = {2'b0, ew[0][2]} + {1'b0, ew[1][2], 1'b0} + {2'b0, ew[2][2]};
        sum_lf = {2'b0, ew[0][0]} + {1'b0, ew[1][0], 1'b0} + {2'b0, ew[2][0]};
        gv = $signed({1'b0, sum_lo}) - $signed({1'b0, sum_hi});
        gh = $signed({1'b0, sum_rt}) - $signed({1'b0, sum_lf});
        if (gv[10]) begin
            cv_next = '0;
        end else if (gv[9:8] != 2'b00) begin
            cv_next = '1;
        end else begin
            cv_next = gv[7:0];
        end
        if (gh[10]) begin
            ch_next = '0;
        end else if (gh[9:8] != 2'b00) begin
            ch_next = '1;
        end else begin
            ch_next = gh[7:0];
        end
    end

    always_comb begin
        if (frame_done) begin
            col_next = '0;
            row_next = '0;
        end else if (row_end) begin
            col_next = '0;
            row_next = row_reg + 1'b1;
        end else begin
            col_next = col_reg + 1'b1;
            row_next = row_reg;
        end
    end

    assign root_bit   = ROOT_W'(1) << {step_reg, 1'b0};
    assign root_trial = res_reg + root_bit;

    // memory port: clearing pass, else write back the shifted rows
    assign mem_we    = clr_reg || ((state_reg == ST_CALC) && !frame_done);
    assign mem_addr  = clr_reg ? clr_addr_reg : col_reg;
    assign mem_wdata = clr_reg ? '0 : {rd_reg[PIX_W-1:0], pix_eff};

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            line_mem[mem_addr] <= mem_wdata;
        end
        if (accept) begin
            rd_reg <= line_mem[col_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            clr_reg       <= 1'b1;
            clr_addr_reg  <= '0;
            width_reg     <= CFG_W'(640);
            height_reg    <= CFG_W'(480);
            col_reg       <= '0;
            row_reg       <= '0;
            out_valid_reg <= 1'b0;
            for (int k = 0; k < 3; k++) begin
                for (int j = 0; j < 3; j++) begin
                    win_reg[k][j] <= '0;
                end
            end
        end else begin
            if (cfg_valid) begin
                case (cfg_index)
                    CFG_FRAME_WIDTH:  width_reg  <= cfg_data;
                    CFG_FRAME_HEIGHT: height_reg <= cfg_data;
                    default: ;
                endcase
            end

            if (clr_reg) begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
                if (clr_addr_reg == COL_W'(MAX_WIDTH - 1)) begin
                    clr_reg <= 1'b0;
                end
            end

            // the put state loads the next word itself
            if (out_valid_reg && m_tready && (state_reg != ST_PUT)) begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        state_reg <= ST_CALC;
                    end
                end
                ST_CALC: begin
                    for (int k = 0; k < 3; k++) begin
                        for (int j = 0; j < 3; j++) begin
                            win_reg[k][j] <= frame_done ? win1[k][j] : win2[k][j];
                        end
                    end
                    col_reg   <= col_next;
                    row_reg   <= row_next;
                    state_reg <= emit ? ST_MUL : ST_IDLE;
                end
                ST_MUL: begin
                    state_reg <= ST_SUM;
                end
                ST_SUM: begin
                    state_reg <= ST_ROOT;
                end
                ST_ROOT: begin
                    if (step_reg == '0) begin
                        state_reg <= ST_PUT;
                    end
                end
                ST_PUT: begin
                    if (put_ok) begin
                        out_valid_reg <= 1'b1;
                        state_reg     <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // datapath registers, no reset
    always_ff @(posedge aclk) begin
        if (accept) begin
            pix_in_reg <= s_tdata;
            flush_reg  <= s_tuser;
        end
        case (state_reg)
            ST_CALC: begin
                cv_reg   <= cv_next;
                ch_reg   <= ch_next;
                last_reg <= frame_done;
            end
            ST_MUL: begin
                sqv_reg <= cv_reg * cv_reg;
                sqh_reg <= ch_reg * ch_reg;
            end
            ST_SUM: begin
                rem_reg  <= ROOT_W'(sqv_reg) + ROOT_W'(sqh_reg);
                res_reg  <= '0;
                step_reg <= STEP_W'(ROOT_STEPS - 1);
            end
            ST_ROOT: begin
                // one result bit a step: subtract when the trial fits
                if (rem_reg >= root_trial) begin
                    rem_reg <= rem_reg - root_trial;
                    res_reg <= (res_reg >> 1) + root_bit;
                end else begin
                    res_reg <= res_reg >> 1;
                end
                step_reg <= step_reg - 1'b1;
            end
            ST_PUT: begin
                if (put_ok) begin
                    out_v_reg    <= cv_reg;
                    out_h_reg    <= ch_reg;
                    out_m_reg    <= (res_reg > ROOT_W'(255)) ? '1 : res_reg[PIX_W-1:0];
                    out_last_reg <= last_reg;
                end
            end
            default: ;
        endcase
    end

endmodule

`default_nettype wire
